// File: design/lpht_pkg.sv
`default_nettype none

package lpht_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_HOME,
    S_INS_RD,
    S_OHASH,
    S_OCMP,
    S_SCAN,
    S_DONE
  } state_e;

  // hold in a hash state until the three-stage home unit has settled
  localparam logic [1:0] HASH_WAIT = 2'd2;

endpackage

`default_nettype wire

// File: design/lpht_ram.sv
`default_nettype none

module lpht_ram #(
  parameter int unsigned WIDTH = 49,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: design/lpht_mod.sv
`default_nettype none

module lpht_mod #(
  parameter int unsigned TABLE_SIZE = 128,
  parameter int unsigned KEY_W      = 16
) (
  input  wire logic                          clk_i,
  input  wire logic [KEY_W-1:0]              key_i,
  output logic      [$clog2(TABLE_SIZE)-1:0] home_o
);

  localparam int unsigned IW = $clog2(TABLE_SIZE);
  localparam int unsigned TW = $clog2(TABLE_SIZE + 1);
  localparam logic [KEY_W-1:0] RECIP = KEY_W'((2 ** KEY_W) / TABLE_SIZE);
  localparam logic [KEY_W+TW-1:0] T_EXT = (KEY_W + TW)'(TABLE_SIZE);

  logic [2*KEY_W-1:0]  prod_q;
  logic [KEY_W-1:0]    key1_q;
  logic [KEY_W-1:0]    key2_q;
  logic [KEY_W-1:0]    qt_q;
  logic [KEY_W-1:0]    quot;
  logic [KEY_W+TW-1:0] qt_full;
  logic [KEY_W-1:0]    diff;
  logic [KEY_W-1:0]    rem;

  // quotient estimate is low by at most one, so one correction step remains
  assign quot    = prod_q[2*KEY_W-1:KEY_W];
  assign qt_full = (KEY_W + TW)'(quot) * T_EXT;
  assign diff    = key2_q - qt_q;
  assign rem     = ((KEY_W + TW)'(diff) >= T_EXT) ? diff - KEY_W'(TABLE_SIZE) : diff;

  always_ff @(posedge clk_i) begin
    prod_q <= (2 * KEY_W)'(key_i) * (2 * KEY_W)'(RECIP);
    key1_q <= key_i;
    qt_q   <= qt_full[KEY_W-1:0];
    key2_q <= key1_q;
    home_o <= IW'(rem);
  end

endmodule

`default_nettype wire

// File: design/linear_probe_hash_table.sv
`default_nettype none
// Sequence: an accepted item waits in S_HASH for the home unit; search or delete walks
// from its home slot in S_SCAN, insert reads the home slot and walks on only if it is taken.
// Throughput: one item at a time; the probe walk reads one slot per cycle from the
// single read port of the slot memory.
// Reset: after rst_ni releases, a clearing pass invalidates every slot
// while in_stall_o stays high.

module linear_probe_hash_table
  import lpht_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = 128,
  parameter int unsigned KEY_BITS   = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [15:0] key_i,
  input  wire logic [31:0] location_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [31:0]      found_location_o
);

  localparam int unsigned KW = (KEY_BITS < 16) ? KEY_BITS : 16;
  localparam int unsigned VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int unsigned WW = 1 + KW + VW;
  localparam int unsigned IW = $clog2(TABLE_SIZE);
  localparam int unsigned CW = $clog2(TABLE_SIZE + 1);
  localparam logic [CW-1:0] T_CNT    = CW'(TABLE_SIZE);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SIZE - 1);

  function automatic logic [IW-1:0] nxt(input logic [IW-1:0] idx);
    nxt = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  state_e         state_q, state_d;
  op_e            op_q, op_d;
  status_e        res_status_q, res_status_d;
  logic [VW-1:0]  res_found_q, res_found_d;
  logic [KW-1:0]  key_q, key_d;
  logic [VW-1:0]  val_q, val_d;
  logic [KW-1:0]  old_key_q, old_key_d;
  logic [VW-1:0]  old_val_q, old_val_d;
  logic [IW-1:0]  h_q, h_d;
  logic           disp_q, disp_d;
  logic [IW-1:0]  rd_idx_q, rd_idx_d;
  logic [IW-1:0]  chk_idx_q, chk_idx_d;
  logic           chk_vld_q, chk_vld_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [1:0]     hcnt_q, hcnt_d;
  logic [CW-1:0]  occ_q, occ_d;
  logic           out_valid_q, out_valid_d;
  logic [1:0]     status_q, status_d;
  logic [VW-1:0]  found_q, found_d;

  logic           ram_we;
  logic [IW-1:0]  ram_waddr;
  logic [WW-1:0]  ram_wdata;
  logic [IW-1:0]  ram_raddr;
  logic [WW-1:0]  ram_rdata;
  logic           r_vld;
  logic [KW-1:0]  r_key;
  logic [VW-1:0]  r_val;
  logic [KW-1:0]  mod_key;
  logic [IW-1:0]  home;
  logic           issue;
  logic           hit_key;
  logic           hit_empty;

  lpht_ram #(
    .WIDTH (WW),
    .DEPTH (TABLE_SIZE)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lpht_mod #(
    .TABLE_SIZE (TABLE_SIZE),
    .KEY_W      (KW)
  ) u_home (
    .clk_i  (clk_i),
    .key_i  (mod_key),
    .home_o (home)
  );

  assign r_vld     = ram_rdata[WW-1];
  assign r_key     = ram_rdata[VW +: KW];
  assign r_val     = ram_rdata[VW-1:0];
  assign mod_key   = (state_q == S_OHASH) ? old_key_q : key_q;
  assign hit_key   = chk_vld_q && r_vld && (r_key == key_q);
  assign hit_empty = chk_vld_q && !r_vld;
  assign issue     = cnt_q < T_CNT;

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign found_location_o = 32'(found_q);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    key_d        = key_q;
    val_d        = val_q;
    old_key_d    = old_key_q;
    old_val_d    = old_val_q;
    h_d          = h_q;
    disp_d       = disp_q;
    rd_idx_d     = rd_idx_q;
    chk_idx_d    = chk_idx_q;
    chk_vld_d    = chk_vld_q;
    cnt_d        = cnt_q;
    hcnt_d       = hcnt_q;
    occ_d        = occ_q;
    out_valid_d  = out_valid_q;
    status_d     = status_q;
    found_d      = found_q;
    ram_we       = 1'b0;
    ram_waddr    = h_q;
    ram_wdata    = '0;
    ram_raddr    = rd_idx_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = rd_idx_q;
        ram_wdata = '0;
        rd_idx_d  = nxt(rd_idx_q);
        if (rd_idx_q == LAST_IDX) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = op_e'(operation_i);
          key_d   = key_i[KW-1:0];
          val_d   = location_i[VW-1:0];
          hcnt_d  = '0;
          state_d = S_HASH;
        end
      end
      S_HASH, S_OHASH: begin
        if (hcnt_q == HASH_WAIT) begin
          hcnt_d  = '0;
          state_d = (state_q == S_HASH) ? S_HOME : S_OCMP;
        end else begin
          hcnt_d = hcnt_q + 2'd1;
        end
      end
      S_HOME: begin
        h_d = home;
        case (op_q)
          OP_INSERT: begin
            if (occ_q == T_CNT) begin
              res_status_d = STAT_FULL;
              res_found_d  = '0;
              state_d      = S_DONE;
            end else begin
              ram_raddr = home;
              state_d   = S_INS_RD;
            end
          end
          OP_SEARCH, OP_DELETE: begin
            rd_idx_d  = home;
            cnt_d     = '0;
            chk_vld_d = 1'b0;
            state_d   = S_SCAN;
          end
          default: begin
            res_status_d = STAT_NOT_FOUND;
            res_found_d  = '0;
            state_d      = S_DONE;
          end
        endcase
      end
      S_INS_RD: begin
        if (!r_vld) begin
          ram_we       = 1'b1;
          ram_waddr    = h_q;
          ram_wdata    = {1'b1, key_q, val_q};
          occ_d        = occ_q + 1'b1;
          res_status_d = STAT_OK;
          res_found_d  = '0;
          state_d      = S_DONE;
        end else begin
          old_key_d = r_key;
          old_val_d = r_val;
          hcnt_d    = '0;
          state_d   = S_OHASH;
        end
      end
      S_OCMP: begin
        // displace a resident whose home is elsewhere
        disp_d = (home != h_q);
        if (home != h_q) begin
          ram_we    = 1'b1;
          ram_waddr = h_q;
          ram_wdata = {1'b1, key_q, val_q};
        end
        rd_idx_d  = nxt(h_q);
        cnt_d     = '0;
        chk_vld_d = 1'b0;
        state_d   = S_SCAN;
      end
      S_SCAN: begin
        ram_raddr = rd_idx_q;
        chk_vld_d = issue;
        chk_idx_d = rd_idx_q;
        if (issue) begin
          rd_idx_d = nxt(rd_idx_q);
          cnt_d    = cnt_q + 1'b1;
        end
        if (op_q == OP_INSERT && hit_empty) begin
          ram_we       = 1'b1;
          ram_waddr    = chk_idx_q;
          ram_wdata    = disp_q ? {1'b1, old_key_q, old_val_q} : {1'b1, key_q, val_q};
          occ_d        = occ_q + 1'b1;
          res_status_d = STAT_OK;
          res_found_d  = '0;
          state_d      = S_DONE;
        end else if (op_q != OP_INSERT && hit_key) begin
          res_status_d = STAT_OK;
          res_found_d  = r_val;
          if (op_q == OP_DELETE) begin
            ram_we    = 1'b1;
            ram_waddr = chk_idx_q;
            ram_wdata = {1'b0, r_key, r_val};
            occ_d     = occ_q - 1'b1;
          end
          state_d = S_DONE;
        end else if (!issue && !chk_vld_q) begin
          res_status_d = STAT_NOT_FOUND;
          res_found_d  = '0;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          found_d     = res_found_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      rd_idx_q    <= '0;
      chk_vld_q   <= 1'b0;
      cnt_q       <= '0;
      hcnt_q      <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_idx_q    <= rd_idx_d;
      chk_vld_q   <= chk_vld_d;
      cnt_q       <= cnt_d;
      hcnt_q      <= hcnt_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    key_q        <= key_d;
    val_q        <= val_d;
    old_key_q    <= old_key_d;
    old_val_q    <= old_val_d;
    h_q          <= h_d;
    disp_q       <= disp_d;
    chk_idx_q    <= chk_idx_d;
    status_q     <= status_d;
    found_q      <= found_d;
  end

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= T_CNT)
    else $error("occupancy exceeds table size");

  a_full_only_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && res_status_q == STAT_FULL) |-> (op_q == OP_INSERT && occ_q == T_CNT))
    else $error("full status without a full table on insert");

  a_lookup_write_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q == S_SCAN && op_q != OP_INSERT)
      |-> (op_q == OP_DELETE && !ram_wdata[WW-1]))
    else $error("lookup scan wrote a valid slot");

  a_accept_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_HASH))
    else $error("accepted beat did not start hashing");
`endif

endmodule

`default_nettype wire
